// File: src/nng_pkg.sv
// Shared types and constants for the nearest neighbor object gate.
package nng_pkg;

  localparam int GATE_W = 15;
  localparam logic [GATE_W-1:0] GATE_RESET = 15'd128;

  // Clamped per-axis distance magnitude and its square.
  localparam int DIFF_W = 17;
  localparam logic [DIFF_W-1:0] DIFF_CLAMP = 17'h10000;
  localparam int SQ_W = 2 * DIFF_W;
  localparam int SUM_W = SQ_W + 1;

  localparam int ID_W = 8;
  localparam int SLOT_OUT_W = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } nng_state_t;

endpackage

// File: src/nng_table_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
module nng_table_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/nng_dist_pipe.sv
// Two-stage squared distance pipe: clamped axis differences, then squares.
module nng_dist_pipe #(
  parameter int COORD_W = 16,
  parameter int SLOT_W  = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  input  logic [SLOT_W-1:0]           in_slot,
  input  logic signed [COORD_W-1:0]   ref_x,
  input  logic signed [COORD_W-1:0]   ref_y,
  input  logic signed [COORD_W-1:0]   det_x,
  input  logic signed [COORD_W-1:0]   det_y,
  output logic                        sq_v,
  output logic [SLOT_W-1:0]           sq_slot,
  output logic signed [COORD_W-1:0]   sq_x,
  output logic signed [COORD_W-1:0]   sq_y,
  output logic [nng_pkg::SQ_W-1:0]    sq_dx,
  output logic [nng_pkg::SQ_W-1:0]    sq_dy,
  output logic                        busy
);

  localparam int EW = (COORD_W + 1 > nng_pkg::DIFF_W) ? COORD_W + 1 : nng_pkg::DIFF_W;

  // stage A
  logic                      va_r;
  logic [SLOT_W-1:0]         slot_a_r;
  logic signed [COORD_W-1:0] x_a_r, y_a_r;
  logic [nng_pkg::DIFF_W-1:0] dx_a_r, dy_a_r;
  // stage B
  logic                      vb_r;
  logic [SLOT_W-1:0]         slot_b_r;
  logic signed [COORD_W-1:0] x_b_r, y_b_r;
  logic [nng_pkg::SQ_W-1:0]  sqx_b_r, sqy_b_r;

  logic [nng_pkg::DIFF_W-1:0] dx_nxt, dy_nxt;

  function automatic logic [nng_pkg::DIFF_W-1:0] clamp_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        mag;
    logic [EW-1:0]           mag_e;
    d     = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag   = d[COORD_W] ? (COORD_W + 1)'(-d) : d;
    mag_e = EW'(mag);
    if (mag_e > EW'(nng_pkg::DIFF_CLAMP)) begin
      return nng_pkg::DIFF_CLAMP;
    end
    return mag_e[nng_pkg::DIFF_W-1:0];
  endfunction

  always_comb begin
    dx_nxt = clamp_diff(det_x, ref_x);
    dy_nxt = clamp_diff(det_y, ref_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_v;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    slot_a_r <= in_slot;
    x_a_r    <= ref_x;
    y_a_r    <= ref_y;
    dx_a_r   <= dx_nxt;
    dy_a_r   <= dy_nxt;
    slot_b_r <= slot_a_r;
    x_b_r    <= x_a_r;
    y_b_r    <= y_a_r;
    sqx_b_r  <= dx_a_r * dx_a_r;
    sqy_b_r  <= dy_a_r * dy_a_r;
  end

  assign sq_v    = vb_r;
  assign sq_slot = slot_b_r;
  assign sq_x    = x_b_r;
  assign sq_y    = y_b_r;
  assign sq_dx   = sqx_b_r;
  assign sq_dy   = sqy_b_r;
  assign busy    = va_r | vb_r;

endmodule

// File: src/nearest_neighbor_object_gate.sv
// Top level of the nearest neighbor object gate: control, best tracking, table update.
// After start is taken the block scans every stored entry with one table memory read each (an
// empty table skips the scan), waits in drain for the read and the two pipe stages to empty,
// then writes back in the finish state, from which the result strobe is registered. busy is high
// from the accepted start until the block is back in idle, so no new word is taken before then.
// Reset (rst_n low, synchronous): table empty, next id zero, gate 128 (0.5 m), no result pending.
module nearest_neighbor_object_gate #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // detection words
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_y,
  input  logic                              in_batch_last,
  // result words; the strobe can overlap the next start and the receiver cannot stall it
  output logic                              out_valid,
  output logic                              out_is_new,
  output logic signed [nng_pkg::ID_W-1:0]   out_object_id,
  output logic signed [COORD_WIDTH-1:0]     out_x,
  output logic signed [COORD_WIDTH-1:0]     out_y,
  output logic [nng_pkg::SLOT_OUT_W-1:0]    out_match_slot,
  output logic                              out_table_full,
  output logic                              out_batch_end,
  // gate register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nng_pkg::GATE_W-1:0]        cfg_gate_distance
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SXW   = (AW > nng_pkg::SLOT_OUT_W) ? AW : nng_pkg::SLOT_OUT_W;
  localparam int MW    = 2 * COORD_WIDTH;

  nng_pkg::nng_state_t state_r, state_nxt;

  logic [nng_pkg::GATE_W-1:0]  gate_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [nng_pkg::ID_W-1:0]    id_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic                        last_r;
  logic [AW-1:0]               rd_idx_r;
  logic                        issue_v_r;
  logic [AW-1:0]               issue_slot_r;

  // running best over the scan
  logic [nng_pkg::SUM_W-1:0]   best_r;
  logic                        found_r;
  logic [AW-1:0]               best_slot_r;
  logic signed [COORD_WIDTH-1:0] best_x_r, best_y_r;

  // result registers
  logic                        out_valid_r;
  logic                        out_is_new_r;
  logic [nng_pkg::ID_W-1:0]    out_id_r;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_y_r;
  logic [nng_pkg::SLOT_OUT_W-1:0] out_slot_r;
  logic                        out_full_r;
  logic                        out_last_r;

  logic                        accept;
  logic                        last_issue;
  logic                        rd_en;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [MW-1:0]               wr_data;
  logic [MW-1:0]               rd_data;
  logic                        table_room;

  logic                        sq_v;
  logic [AW-1:0]               sq_slot;
  logic signed [COORD_WIDTH-1:0] sq_x, sq_y;
  logic [nng_pkg::SQ_W-1:0]    sq_dx, sq_dy;
  logic                        pipe_busy;
  logic [nng_pkg::SUM_W-1:0]   d2;
  logic                        better;

  logic signed [COORD_WIDTH:0] avg_x_sum, avg_y_sum;
  logic signed [COORD_WIDTH-1:0] avg_x, avg_y;
  logic [SXW-1:0]              slot_ext;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != nng_pkg::ST_IDLE);
  assign accept    = start && !busy;

  // last entry issued when idx + 1 reaches the count
  assign last_issue = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == cnt_r);
  assign table_room = (cnt_r < CNT_W'(TABLE_DEPTH));

  // ---------------- state machine ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nng_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (cnt_r == '0) ? nng_pkg::ST_DRAIN : nng_pkg::ST_SCAN;
        end
      end
      nng_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_nxt = nng_pkg::ST_DRAIN;
        end
      end
      nng_pkg::ST_DRAIN: begin
        if (!issue_v_r && !pipe_busy && !sq_v) begin
          state_nxt = nng_pkg::ST_FINISH;
        end
      end
      nng_pkg::ST_FINISH: begin
        state_nxt = nng_pkg::ST_IDLE;
      end
      default: state_nxt = nng_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    wr_en = 1'b0;
    unique case (state_r)
      nng_pkg::ST_IDLE:   ;
      nng_pkg::ST_SCAN:   rd_en = 1'b1;
      nng_pkg::ST_DRAIN:  ;
      nng_pkg::ST_FINISH: wr_en = found_r || table_room;
      default:            ;
    endcase
  end

  // ---------------- table memory, words are {x, y} ----------------
  // Reads only happen during the scan and the single write in the finish
  // cycle, so the same entry is never read and written in overlapping cycles.
  always_comb begin
    avg_x_sum = {best_x_r[COORD_WIDTH-1], best_x_r} + {px_r[COORD_WIDTH-1], px_r};
    avg_y_sum = {best_y_r[COORD_WIDTH-1], best_y_r} + {py_r[COORD_WIDTH-1], py_r};
    avg_x     = avg_x_sum[COORD_WIDTH:1];   // floor halving
    avg_y     = avg_y_sum[COORD_WIDTH:1];
    if (found_r) begin
      wr_addr = best_slot_r;
      wr_data = {avg_x, avg_y};
    end else begin
      wr_addr = cnt_r[AW-1:0];
      wr_data = {px_r, py_r};
    end
  end

  nng_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  nng_dist_pipe #(
    .COORD_W (COORD_WIDTH),
    .SLOT_W  (AW)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (issue_v_r),
    .in_slot (issue_slot_r),
    .ref_x   (rd_data[MW-1:COORD_WIDTH]),
    .ref_y   (rd_data[COORD_WIDTH-1:0]),
    .det_x   (px_r),
    .det_y   (py_r),
    .sq_v    (sq_v),
    .sq_slot (sq_slot),
    .sq_x    (sq_x),
    .sq_y    (sq_y),
    .sq_dx   (sq_dx),
    .sq_dy   (sq_dy),
    .busy    (pipe_busy)
  );

  // strict compare keeps the earliest entry on a tie
  assign d2     = nng_pkg::SUM_W'(sq_dx) + nng_pkg::SUM_W'(sq_dy);
  assign better = sq_v && (d2 < best_r);

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nng_pkg::ST_IDLE;
      gate_r      <= nng_pkg::GATE_RESET;
      cnt_r       <= '0;
      id_r        <= '0;
      issue_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_v_r   <= rd_en;
      out_valid_r <= (state_r == nng_pkg::ST_FINISH);
      if (cfg_valid && cfg_ready) begin
        gate_r <= cfg_gate_distance;
      end
      if (state_r == nng_pkg::ST_FINISH && !found_r) begin
        id_r <= id_r + 1'b1;
        if (table_room) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    issue_slot_r <= rd_idx_r;
    if (accept) begin
      px_r     <= in_pos_x;
      py_r     <= in_pos_y;
      last_r   <= in_batch_last;
      rd_idx_r <= '0;
      best_r   <= nng_pkg::SUM_W'(gate_r) * nng_pkg::SUM_W'(gate_r);
      found_r  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (better) begin
        best_r      <= d2;
        found_r     <= 1'b1;
        best_slot_r <= sq_slot;
        best_x_r    <= sq_x;
        best_y_r    <= sq_y;
      end
    end
  end

  // ---------------- result word ----------------
  always_comb begin
    if (found_r) begin
      slot_ext = SXW'(best_slot_r);
    end else if (table_room) begin
      slot_ext = SXW'(cnt_r[AW-1:0]);
    end else begin
      slot_ext = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == nng_pkg::ST_FINISH) begin
      out_is_new_r <= !found_r;
      out_id_r     <= found_r ? '0 : id_r;
      out_x_r      <= found_r ? avg_x : px_r;
      out_y_r      <= found_r ? avg_y : py_r;
      out_slot_r   <= slot_ext[nng_pkg::SLOT_OUT_W-1:0];
      out_full_r   <= !found_r && !table_room;
      out_last_r   <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_new     = out_is_new_r;
  assign out_object_id  = out_id_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_match_slot = out_slot_r;
  assign out_table_full = out_full_r;
  assign out_batch_end  = out_last_r;

`ifndef NO_ASSERTIONS
  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == nng_pkg::ST_FINISH))
    else $error("result strobe without finish cycle");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CNT_W'(rd_idx_r) < cnt_r))
    else $error("scan read past stored entries");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after start");

  a_match_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_new_r) |-> (!out_full_r && out_id_r == '0))
    else $error("matched word flagged full or carries an id");
`endif

endmodule

// File: dv/nng_association_checker.sv
// Association checker: predicts each detection's result word and compares it with the DUT.
module nng_association_checker #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]       in_pos_y,
  input  logic                                in_batch_last,
  input  logic                                out_valid,
  input  logic                                out_is_new,
  input  logic signed [nng_pkg::ID_W-1:0]     out_object_id,
  input  logic signed [COORD_WIDTH-1:0]       out_x,
  input  logic signed [COORD_WIDTH-1:0]       out_y,
  input  logic [nng_pkg::SLOT_OUT_W-1:0]      out_match_slot,
  input  logic                                out_table_full,
  input  logic                                out_batch_end,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [nng_pkg::GATE_W-1:0]          cfg_gate_distance,
  output int                                  mismatch_count,
  output int                                  tracks_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct {
    logic                                is_new;
    logic signed [nng_pkg::ID_W-1:0]     object_id;
    coord_t                              x;
    coord_t                              y;
    logic [nng_pkg::SLOT_OUT_W-1:0]      slot;
    logic                                full;
    logic                                batch_end;
  } track_t;

  logic [nng_pkg::GATE_W-1:0] gate_q;
  coord_t                     known_x [TABLE_DEPTH];
  coord_t                     known_y [TABLE_DEPTH];
  int                         known_count;
  logic [nng_pkg::ID_W-1:0]   next_id;
  track_t                     expected_tracks [$];

  initial begin
    mismatch_count = 0;
    tracks_pending = 0;
  end

  // |a - b| on one axis, clamped like the hardware's 17-bit magnitude
  function automatic longint axis_gap(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return (d > longint'(nng_pkg::DIFF_CLAMP)) ? longint'(nng_pkg::DIFF_CLAMP) : d;
  endfunction

  // floor((a + b) / 2)
  function automatic coord_t midpoint(coord_t a, coord_t b);
    longint s;
    s = (longint'(a) + longint'(b)) >>> 1;
    return coord_t'(s);
  endfunction

  // Nearest-entry search, then either merge into the match or append a new object.
  function automatic track_t associate_detection(coord_t px, coord_t py, logic last);
    track_t r;
    longint best;
    longint d2;
    int     hit;
    best = longint'(gate_q) * longint'(gate_q);
    hit  = -1;
    for (int i = 0; i < known_count; i++) begin
      d2 = axis_gap(px, known_x[i]) * axis_gap(px, known_x[i])
         + axis_gap(py, known_y[i]) * axis_gap(py, known_y[i]);
      if (d2 < best) begin
        best = d2;
        hit  = i;
      end
    end
    r.batch_end = last;
    if (hit >= 0) begin
      known_x[hit] = midpoint(known_x[hit], px);
      known_y[hit] = midpoint(known_y[hit], py);
      r.is_new    = 1'b0;
      r.object_id = '0;
      r.x         = known_x[hit];
      r.y         = known_y[hit];
      r.slot      = hit[nng_pkg::SLOT_OUT_W-1:0];
      r.full      = 1'b0;
    end else begin
      r.is_new    = 1'b1;
      r.object_id = next_id;
      next_id     = next_id + 1'b1;
      r.x         = px;
      r.y         = py;
      if (known_count < TABLE_DEPTH) begin
        known_x[known_count] = px;
        known_y[known_count] = py;
        r.slot = known_count[nng_pkg::SLOT_OUT_W-1:0];
        r.full = 1'b0;
        known_count++;
      end else begin
        r.slot = '0;
        r.full = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    track_t want;
    if (!rst_n) begin
      gate_q      = nng_pkg::GATE_RESET;
      known_count = 0;
      next_id     = '0;
      expected_tracks.delete();
    end else begin
      // result of an older word first; a new start may land on the same edge
      if (out_valid) begin
        if (expected_tracks.size() == 0) begin
          $error("result word with no detection outstanding");
          mismatch_count++;
        end else begin
          want = expected_tracks.pop_front();
          check_field("is_new",     want.is_new,    out_is_new);
          check_field("object_id",  want.object_id, out_object_id);
          check_field("out_x",      want.x,         out_x);
          check_field("out_y",      want.y,         out_y);
          check_field("match_slot", want.slot,      out_match_slot);
          check_field("table_full", want.full,      out_table_full);
          check_field("batch_end",  want.batch_end, out_batch_end);
        end
      end
      if (cfg_valid && cfg_ready) gate_q = cfg_gate_distance;
      if (start && !busy) begin
        want = associate_detection(in_pos_x, in_pos_y, in_batch_last);
        expected_tracks.insert(expected_tracks.size(), want);
      end
    end
    tracks_pending = expected_tracks.size();
  end

endmodule

// File: dv/tb_nearest_neighbor_object_gate.sv
// Testbench top for the nearest neighbor object gate: stimulus, gate settings and verdict.
module tb_nearest_neighbor_object_gate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH   = 64;
  localparam int COORD_WIDTH   = 16;
  // slowest word is a full-table scan plus a long gap; 1769 words fit many times over
  localparam int CYCLE_LIMIT   = 1_500_000;
  // a full-table scan plus pipe and write-back, with margin
  localparam int SETTLE_CYCLES = 80;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  coord_t                             in_pos_x;
  coord_t                             in_pos_y;
  logic                               in_batch_last;
  logic                               out_valid;
  logic                               out_is_new;
  logic signed [nng_pkg::ID_W-1:0]    out_object_id;
  coord_t                             out_x;
  coord_t                             out_y;
  logic [nng_pkg::SLOT_OUT_W-1:0]     out_match_slot;
  logic                               out_table_full;
  logic                               out_batch_end;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [nng_pkg::GATE_W-1:0]         cfg_gate_distance;

  int mismatch_count;
  int tracks_pending;

  // gate currently programmed, used to aim detections near or just past the threshold
  int cur_gate;
  // set for stretches of back-to-back words
  bit no_idle;

  // Table contents as the DUT reports them: every stored or merged word carries its slot
  // and the position now held there, so these are exact anchors for close detections.
  coord_t seen_x [TABLE_DEPTH];
  coord_t seen_y [TABLE_DEPTH];
  int     seen_count = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  nearest_neighbor_object_gate #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_batch_last     (in_batch_last),
    .out_valid         (out_valid),
    .out_is_new        (out_is_new),
    .out_object_id     (out_object_id),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_match_slot    (out_match_slot),
    .out_table_full    (out_table_full),
    .out_batch_end     (out_batch_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_gate_distance (cfg_gate_distance)
  );

  nng_association_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_batch_last     (in_batch_last),
    .out_valid         (out_valid),
    .out_is_new        (out_is_new),
    .out_object_id     (out_object_id),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_match_slot    (out_match_slot),
    .out_table_full    (out_table_full),
    .out_batch_end     (out_batch_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_gate_distance (cfg_gate_distance),
    .mismatch_count    (mismatch_count),
    .tracks_pending    (tracks_pending)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_table_full) begin
      seen_x[out_match_slot] <= out_x;
      seen_y[out_match_slot] <= out_y;
      if (int'(out_match_slot) >= seen_count) seen_count <= int'(out_match_slot) + 1;
    end
  end

  function automatic coord_t clip(longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return coord_t'(v);
  endfunction

  function automatic longint jitter(int m);
    return longint'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic coord_t corner_value();
    case ($urandom_range(0, 3))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly short gaps, some long ones, none at all during a no-idle stretch.
  function automatic int idle_cycles();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  // Present one detection word at a falling edge and hold it until it is taken.
  task automatic send_detection(coord_t x, coord_t y, logic last);
    int gap;
    start         = 1'b1;
    in_pos_x      = x;
    in_pos_y      = y;
    in_batch_last = last;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = idle_cycles();
    if (gap > 0) begin
      // idle fields carry junk; the DUT must ignore them
      start         = 1'b0;
      in_pos_x      = coord_t'($urandom());
      in_pos_y      = coord_t'($urandom());
      in_batch_last = $urandom_range(0, 1);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Reprogram the gate once every result word is back; each word yields exactly one
  // result, so an empty expectation queue means the DUT is idle.
  task automatic set_gate(int g);
    start = 1'b0;
    while (tracks_pending != 0) @(negedge clk);
    cfg_valid         = 1'b1;
    cfg_gate_distance = g[nng_pkg::GATE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_gate  = g;
  endtask

  // Random detection, mostly aimed at known entries: well inside the gate, right at
  // its edge, or exactly on top; the rest is scattered and corner values.
  task automatic pick_detection(output coord_t x, output coord_t y, output logic last);
    int     mode;
    int     span;
    int     s;
    coord_t ax;
    coord_t ay;
    last = ($urandom_range(0, 3) == 0);
    mode = (seen_count == 0) ? 85 : $urandom_range(0, 99);
    span = (cur_gate < 2) ? 1 : cur_gate;
    s    = (seen_count == 0) ? 0 : $urandom_range(0, seen_count - 1);
    ax   = seen_x[s];
    ay   = seen_y[s];
    if (mode < 55) begin
      x = clip(longint'(ax) + jitter(span / 2));
      y = clip(longint'(ay) + jitter(span / 2));
    end else if (mode < 70) begin
      // distance one below, at, or one past the gate along x
      x = clip(longint'(ax) + ($urandom_range(0, 1) ? 1 : -1)
                              * (span - 1 + int'($urandom_range(0, 2))));
      y = ay;
    end else if (mode < 80) begin
      x = ax;
      y = ay;
    end else if (mode < 93) begin
      x = coord_t'($urandom());
      y = coord_t'($urandom());
    end else begin
      x = corner_value();
      y = corner_value();
    end
  endtask

  initial begin
    int     gates [6];
    int     counts [6];
    coord_t x;
    coord_t y;
    logic   last;

    rst_n             = 1'b0;
    start             = 1'b0;
    in_pos_x          = '0;
    in_pos_y          = '0;
    in_batch_last     = 1'b0;
    cfg_valid         = 1'b0;
    cfg_gate_distance = '0;
    cur_gate          = int'(nng_pkg::GATE_RESET);
    no_idle           = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words under the reset gate (0.5 m), back to back first.
    send_detection(0, 0, 1'b0);               // empty table: new object in slot 0
    send_detection(128, 0, 1'b1);             // exactly at the gate: not a match
    send_detection(-127, 0, 1'b0);            // just inside: merge, negative floor average
    send_detection(C_MIN, C_MIN, 1'b0);       // corners, largest coordinate differences
    send_detection(C_MAX, C_MAX, 1'b1);
    send_detection(C_MIN, C_MAX, 1'b0);
    send_detection(C_MAX, C_MIN, 1'b0);
    send_detection(C_MIN, C_MIN, 1'b1);       // zero distance on a corner entry
    send_detection(C_MAX, C_MAX - 1, 1'b0);   // odd sum at the top end
    no_idle = 1'b0;
    send_detection(5000, 5000, 1'b0);         // two entries 200 apart...
    send_detection(5200, 5000, 1'b0);
    send_detection(5100, 5000, 1'b1);         // ...and a tie between them: earlier wins
    send_detection(-301, -301, 1'b0);
    send_detection(-300, -300, 1'b0);         // merge rounds down to -301
    send_detection(-1, -1, 1'b1);
    send_detection(16'sh5555, 16'shAAAA, 1'b0);
    send_detection(16'shAAAA, 16'sh5555, 1'b1);
    send_detection(1000, 1000, 1'b0);
    send_detection(1090, 1090, 1'b1);         // diagonal, squared sum 16200 just below the gate's 16384

    // Random phases: a mid gate, zero gate (nothing matches, ids wrap, table fills),
    // widest gate, unit gate (only exact hits), a random gate, then back to reset value.
    gates[0]  = $urandom_range(64, 2047);
    gates[1]  = 0;
    gates[2]  = (1 << nng_pkg::GATE_W) - 1;
    gates[3]  = 1;
    gates[4]  = $urandom_range(0, (1 << nng_pkg::GATE_W) - 1);
    gates[5]  = int'(nng_pkg::GATE_RESET);
    counts[0] = 450;
    counts[1] = 300;
    counts[2] = 250;
    counts[3] = 200;
    counts[4] = 250;
    counts[5] = 300;
    for (int p = 0; p < 6; p++) begin
      set_gate(gates[p]);
      for (int n = 0; n < counts[p]; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        pick_detection(x, y, last);
        send_detection(x, y, last);
      end
    end

    // drain, then give the DUT a full scan's worth of cycles to show anything stray
    start = 1'b0;
    while (tracks_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && tracks_pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // hang guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

endmodule

// File: nearest_neighbor_object_gate.f
src/nng_pkg.sv
src/nng_table_mem.sv
src/nng_dist_pipe.sv
src/nearest_neighbor_object_gate.sv
dv/nng_association_checker.sv
dv/tb_nearest_neighbor_object_gate.sv
